/* design/gstr_pkg.sv */
package gstr_pkg;

    localparam int SPS_MAX_DEF     = 16;
    localparam int RING_DEPTH_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SPS_W   = 5;
    localparam int GAIN_W  = 26;
    localparam int IDX_W   = 32;
    localparam int ERR_W   = 34;
    localparam int TAU_W   = 6;
    localparam int PHASE_W = 32;

    localparam logic [1:0] CFG_SPS       = 2'd0;
    localparam logic [1:0] CFG_GAIN_PROP = 2'd1;
    localparam logic [1:0] CFG_GAIN_INT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_EARLY,
        ST_RD_MID,
        ST_RD_LATE,
        ST_ERR,
        ST_MUL,
        ST_PHASE,
        ST_TAU,
        ST_RD_STROBE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       rd_early;
        logic       rd_mid;
        logic       rd_late;
        logic       calc_err;
        logic       calc_mul;
        logic       calc_phase;
        logic       calc_tau;
        logic       rd_strobe;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic sym_ready;
    } t_status;

endpackage

/* design/gardner_symbol_timing_recovery_unit.sv */
// The result word is loaded after the early/mid/late reads, loop update and strobe read.
// Throughput: one sample word per cycle while no symbol is due; a due symbol holds
// s_axis_tready low while it is worked (serial ring reads, multiplies, PI update) and
// while the previous result word still waits for m_axis_tready.
// Reset (i_rst_n low, synchronous): counters, loop phase, tau and configuration registers
// return to defaults; ring entries read as zero until written.
module gardner_symbol_timing_recovery_unit #(
    parameter int SPS_MAX     = gstr_pkg::SPS_MAX_DEF,
    parameter int RING_DEPTH  = gstr_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = gstr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*SAMPLE_BITS-1:0]      s_axis_tdata,  // in_i, in_q
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [103:0]                  m_axis_tdata,  // sym_i, sym_q, strobe, err, tau
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [gstr_pkg::GAIN_W-1:0]   i_cfg_data
);
    import gstr_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    busy, in_acc, r_ovld;
    logic signed [SAMPLE_BITS-1:0] sym_i, sym_q;
    logic [IDX_W-1:0] strobe;
    logic signed [ERR_W-1:0] err;
    logic signed [TAU_W-1:0] tau;

    // input halts while a symbol is being worked
    assign s_axis_tready = !busy && !st.sym_ready;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    gstr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_status(st),
        .i_out_free(!r_ovld || m_axis_tready), .o_cmd(cmd), .o_busy(busy)
    );

    gstr_dp #(.SPS_MAX(SPS_MAX), .RING_DEPTH(RING_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_acc(in_acc),
        .i_in_i(s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_in_q(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_status(st), .o_sym_i(sym_i), .o_sym_q(sym_q),
        .o_strobe(strobe), .o_err(err), .o_tau(tau)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (cmd.load_out) r_ovld <= 1'b1;
        else if (m_axis_tready) r_ovld <= 1'b0;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = {tau, err, strobe, sym_q, sym_i};
endmodule

/* design/gstr_ctrl.sv */
module gstr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gstr_pkg::t_status i_status,
    input  logic             i_out_free,
    output gstr_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import gstr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_status.sym_ready) begin
                    o_cmd.rd_early = 1'b1;
                    n_state = ST_RD_EARLY;
                end
            end
            ST_RD_EARLY: begin
                o_cmd.rd_mid = 1'b1;
                n_state = ST_RD_MID;
            end
            ST_RD_MID: begin
                o_cmd.rd_late = 1'b1;
                n_state = ST_RD_LATE;
            end
            ST_RD_LATE: n_state = ST_ERR;
            ST_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state = ST_PHASE;
            end
            ST_PHASE: begin
                o_cmd.calc_phase = 1'b1;
                n_state = ST_TAU;
            end
            ST_TAU: begin
                o_cmd.calc_tau = 1'b1;
                n_state = ST_RD_STROBE;
            end
            ST_RD_STROBE: begin
                o_cmd.rd_strobe = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

/* design/gstr_dp.sv */
module gstr_dp #(
    parameter int SPS_MAX     = gstr_pkg::SPS_MAX_DEF,
    parameter int RING_DEPTH  = gstr_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = gstr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_acc,
    input  logic signed [SAMPLE_BITS-1:0]     i_in_i,
    input  logic signed [SAMPLE_BITS-1:0]     i_in_q,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [gstr_pkg::GAIN_W-1:0]       i_cfg_data,
    input  gstr_pkg::t_cmd                    i_cmd,
    output gstr_pkg::t_status                 o_status,
    output logic signed [SAMPLE_BITS-1:0]     o_sym_i,
    output logic signed [SAMPLE_BITS-1:0]     o_sym_q,
    output logic [gstr_pkg::IDX_W-1:0]        o_strobe,
    output logic signed [gstr_pkg::ERR_W-1:0] o_err,
    output logic signed [gstr_pkg::TAU_W-1:0] o_tau
);
    import gstr_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int SMW = $clog2(SPS_MAX + 1);
    localparam int RGW = 2 * SAMPLE_BITS;
    localparam int DW  = SAMPLE_BITS + 1;
    localparam int PW  = 2 * SAMPLE_BITS + 1;
    localparam int MW  = ERR_W + GAIN_W;

    logic [RGW-1:0] r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;
    logic [RGW-1:0] r_rd_data;
    logic           r_rd_vld;
    logic           r_new;

    logic [SPS_W-1:0]         r_sps;
    logic signed [GAIN_W-1:0] r_kp, r_ki;
    logic [IDX_W-1:0]         r_count, r_base;
    logic signed [PHASE_W-1:0] r_phase;
    logic signed [TAU_W-1:0]  r_tau;

    logic signed [SAMPLE_BITS-1:0] r_ei, r_eq, r_mi, r_mq, r_li, r_lq;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [MW-1:0]     r_m1, r_m2;
    logic [IDX_W-1:0]         r_strobe_idx;
    logic [2:0]               r_rd_tag;

    logic [SMW-1:0]  s_eff;
    logic [IDX_W-1:0] s_ext, early_idx, mid_idx, late_idx, strobe_n, lag;
    logic            rd_en;
    logic [AW-1:0]   rd_sel;
    logic signed [DW-1:0] d_i, d_q;
    logic signed [PW:0]   err_n;
    logic signed [MW-24:0] t1, t2;
    logic signed [MW-22:0] p_sum, p_a, p_b;
    logic signed [PHASE_W+SMW:0] ps_prod;
    logic signed [TAU_W-1:0] tau_n;

    always_comb begin
        if (r_sps < SPS_W'(2))
            s_eff = SMW'(2);
        else if ({1'b0, r_sps} > (SPS_W + 1)'(SPS_MAX))
            s_eff = SMW'(SPS_MAX);
        else
            s_eff = SMW'(r_sps);
    end
    assign s_ext     = IDX_W'(s_eff);
    // a symbol is only taken up right after the word that may complete it
    assign lag       = r_count - 1'b1 - r_base;
    assign o_status.sym_ready = r_new && !lag[IDX_W-1]
                                && lag >= (s_ext << 1);
    assign early_idx = r_base + IDX_W'(r_tau);
    assign mid_idx   = early_idx + (s_ext >> 1);
    assign late_idx  = early_idx + s_ext;

    always_comb begin
        rd_en  = 1'b1;
        rd_sel = early_idx[AW-1:0];
        if (i_cmd.rd_mid)         rd_sel = mid_idx[AW-1:0];
        else if (i_cmd.rd_late)   rd_sel = late_idx[AW-1:0];
        else if (i_cmd.rd_strobe) rd_sel = r_strobe_idx[AW-1:0];
        else if (!i_cmd.rd_early) rd_en  = 1'b0;
    end

    // ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_in_acc) r_ring[r_count[AW-1:0]] <= {i_in_q, i_in_i};
        if (rd_en) begin
            r_rd_data <= r_ring[rd_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_new    <= 1'b0;
        end else begin
            r_new <= i_in_acc;
            if (i_in_acc) r_vld[r_count[AW-1:0]] <= 1'b1;
            if (rd_en) r_rd_vld <= r_vld[rd_sel] && !(i_in_acc && rd_sel == r_count[AW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_tag <= '0;
        else r_rd_tag <= {i_cmd.rd_late, i_cmd.rd_mid, i_cmd.rd_early | i_cmd.rd_strobe};
    end

    logic signed [SAMPLE_BITS-1:0] rd_i, rd_q;
    assign rd_i = r_rd_vld ? r_rd_data[SAMPLE_BITS-1:0]   : '0;
    assign rd_q = r_rd_vld ? r_rd_data[RGW-1:SAMPLE_BITS] : '0;

    assign d_i   = DW'(r_li) - DW'(r_ei);
    assign d_q   = DW'(r_lq) - DW'(r_eq);
    assign err_n = (PW+1)'(d_i) * (PW+1)'(r_mi) + (PW+1)'(d_q) * (PW+1)'(r_mq);
    assign t1 = (MW-23)'(r_m1 >>> 24);
    assign t2 = (MW-23)'(r_m2 >>> 24);

    always_comb begin
        p_sum = (MW-21)'(r_phase) + (MW-21)'(t1) + (MW-21)'(t2);
        p_a = p_sum;
        if (p_a > (MW-21)'(64'sd1 <<< 30))  p_a = p_a - (MW-21)'(64'sd1 <<< 30);
        if (p_a < -((MW-21)'(64'sd1 <<< 30))) p_a = p_a + (MW-21)'(64'sd1 <<< 30);
        p_b = p_a;
        if (p_b > (MW-21)'(64'sd1 <<< 30))  p_b = (MW-21)'(64'sd1 <<< 30);
        if (p_b < -((MW-21)'(64'sd1 <<< 30))) p_b = -((MW-21)'(64'sd1 <<< 30));
    end

    // ceil(p*sps/2^30)
    assign ps_prod = (PHASE_W+SMW+1)'(r_phase) * $signed({1'b0, s_eff});
    assign tau_n   = TAU_W'((ps_prod + (PHASE_W+SMW+1)'((64'sd1 <<< 30) - 1)) >>> 30);
    assign strobe_n = r_base + s_ext + IDX_W'(r_tau);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps   <= SPS_W'(8);
            r_kp    <= -GAIN_W'(2796203);
            r_ki    <= -GAIN_W'(47);
            r_count <= '0;
            r_base  <= '0;
            r_phase <= '0;
            r_tau   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPS:       r_sps <= i_cfg_data[SPS_W-1:0];
                    CFG_GAIN_PROP: r_kp  <= i_cfg_data;
                    CFG_GAIN_INT:  r_ki  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_acc) r_count <= r_count + 1'b1;
            if (i_cmd.calc_phase) r_phase <= PHASE_W'(p_b);
            if (i_cmd.calc_tau) r_tau <= tau_n;
            if (i_cmd.load_out) r_base <= r_base + s_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_tag[0] && !i_cmd.rd_late && !i_cmd.calc_err && !i_cmd.load_out
            && !i_cmd.calc_tau) begin
            r_ei <= rd_i;
            r_eq <= rd_q;
        end
        if (r_rd_tag[1]) begin r_mi <= rd_i; r_mq <= rd_q; end
        if (r_rd_tag[2]) begin r_li <= rd_i; r_lq <= rd_q; end
        if (i_cmd.calc_err) r_err <= ERR_W'(err_n);
        if (i_cmd.calc_mul) begin
            r_m1 <= MW'(r_err) * MW'(r_kp);
            r_m2 <= MW'(r_err) * MW'(r_ki);
        end
        if (i_cmd.rd_strobe) r_strobe_idx <= strobe_n;
        if (i_cmd.calc_tau) r_strobe_idx <= r_base + s_ext + IDX_W'(tau_n);
        if (i_cmd.load_out) begin
            o_sym_i  <= rd_i;
            o_sym_q  <= rd_q;
            o_strobe <= r_strobe_idx;
            o_err    <= r_err;
            o_tau    <= r_tau;
        end
    end
endmodule
